[design/qpr_pkg.sv]
// Shared types and constants of the quaternion point rotator.
// Holds widths, register indexes and payload structs; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package qpr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int QUAT_WIDTH  = 16;
    localparam int QFRAC       = QUAT_WIDTH - 2;
    localparam int RSHIFT      = 2 * QFRAC;

    // datapath widths, all exact
    localparam int QP_W   = 2 * QUAT_WIDTH;
    localparam int COEF_W = QP_W + 2;
    localparam int MUL_W  = COEF_W + COORD_WIDTH;
    localparam int SUM_W  = MUL_W + 2;
    localparam int RND_W  = SUM_W - RSHIFT;
    localparam int OFS_W  = RND_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

    localparam logic signed [QUAT_WIDTH-1:0]  QUAT_ONE  = QUAT_WIDTH'(1) << QFRAC;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          saturated;
    } t_result;

    // one row of the rotation matrix, Q2.28 scale
    typedef struct packed {
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
    } t_coef_row;

    typedef struct packed {
        t_coef_row row_x;
        t_coef_row row_y;
        t_coef_row row_z;
    } t_coef_mat;

endpackage
`default_nettype wire

[design/qpr_coef.sv]
// Rotation matrix builder: quaternion parts to the nine matrix coefficients.
// Two register stages (pair products, then sums); depends on qpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpr_coef
    import qpr_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qw,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qx,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qy,
    input  wire logic signed [QUAT_WIDTH-1:0] i_qz,
    output t_coef_mat                         o_coef
);

    function automatic logic signed [QP_W-1:0] mul_q(input logic signed [QUAT_WIDTH-1:0] a,
                                                     input logic signed [QUAT_WIDTH-1:0] b);
        logic signed [QP_W-1:0] ea;
        logic signed [QP_W-1:0] eb;
        ea = {{(QP_W-QUAT_WIDTH){a[QUAT_WIDTH-1]}}, a};
        eb = {{(QP_W-QUAT_WIDTH){b[QUAT_WIDTH-1]}}, b};
        mul_q = ea * eb;
    endfunction

    function automatic logic signed [COEF_W-1:0] ext(input logic signed [QP_W-1:0] v);
        ext = {{(COEF_W-QP_W){v[QP_W-1]}}, v};
    endfunction

    logic signed [QP_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_coef_mat r_coef;
    t_coef_mat n_coef;

    // pair products
    always_ff @(posedge i_clk) begin
        r_ww <= mul_q(i_qw, i_qw);
        r_xx <= mul_q(i_qx, i_qx);
        r_yy <= mul_q(i_qy, i_qy);
        r_zz <= mul_q(i_qz, i_qz);
        r_xy <= mul_q(i_qx, i_qy);
        r_xz <= mul_q(i_qx, i_qz);
        r_yz <= mul_q(i_qy, i_qz);
        r_wx <= mul_q(i_qw, i_qx);
        r_wy <= mul_q(i_qw, i_qy);
        r_wz <= mul_q(i_qw, i_qz);
    end

    always_comb begin
        n_coef.row_x.c0 = ext(r_ww) + ext(r_xx) - ext(r_yy) - ext(r_zz);
        n_coef.row_x.c1 = (ext(r_xy) - ext(r_wz)) <<< 1;
        n_coef.row_x.c2 = (ext(r_xz) + ext(r_wy)) <<< 1;
        n_coef.row_y.c0 = (ext(r_xy) + ext(r_wz)) <<< 1;
        n_coef.row_y.c1 = ext(r_ww) - ext(r_xx) + ext(r_yy) - ext(r_zz);
        n_coef.row_y.c2 = (ext(r_yz) - ext(r_wx)) <<< 1;
        n_coef.row_z.c0 = (ext(r_xz) - ext(r_wy)) <<< 1;
        n_coef.row_z.c1 = (ext(r_yz) + ext(r_wx)) <<< 1;
        n_coef.row_z.c2 = ext(r_ww) - ext(r_xx) - ext(r_yy) + ext(r_zz);
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule
`default_nettype wire

[design/qpr_lane.sv]
// One output coordinate: dot product with a matrix row, rounding, offset, saturation.
// Four register stages; depends on qpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpr_lane
    import qpr_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire t_coef_row                     i_row,
    input  wire t_point                        i_point,
    input  wire logic signed [COORD_WIDTH-1:0] i_offset,
    output logic signed [COORD_WIDTH-1:0]      o_value,
    output logic                               o_sat
);

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (RSHIFT - 1);

    function automatic logic signed [MUL_W-1:0] mul_cp(input logic signed [COEF_W-1:0] c,
                                                       input logic signed [COORD_WIDTH-1:0] p);
        logic signed [MUL_W-1:0] ec;
        logic signed [MUL_W-1:0] ep;
        ec = {{(MUL_W-COEF_W){c[COEF_W-1]}}, c};
        ep = {{(MUL_W-COORD_WIDTH){p[COORD_WIDTH-1]}}, p};
        mul_cp = ec * ep;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [MUL_W-1:0] v);
        ext = {{(SUM_W-MUL_W){v[MUL_W-1]}}, v};
    endfunction

    logic signed [MUL_W-1:0]       r_p0, r_p1, r_p2;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [OFS_W-1:0]       r_ofs;
    logic signed [OFS_W-1:0]       n_ofs;
    logic signed [COORD_WIDTH-1:0] r_value;
    logic signed [COORD_WIDTH-1:0] n_value;
    logic                          r_sat;
    logic                          n_sat;
    logic                          fits;

    // one product per matrix column
    always_ff @(posedge i_clk) begin
        r_p0 <= mul_cp(i_row.c0, i_point.point_x);
        r_p1 <= mul_cp(i_row.c1, i_point.point_y);
        r_p2 <= mul_cp(i_row.c2, i_point.point_z);
    end

    // exact sum with the rounding half folded in
    always_ff @(posedge i_clk) begin
        r_sum <= ext(r_p0) + ext(r_p1) + ext(r_p2) + HALF;
    end

    // drop the fraction bits, then add the offset
    always_comb begin
        n_ofs = $signed({r_sum[SUM_W-1], r_sum[SUM_W-1:RSHIFT]})
              + $signed({{(OFS_W-COORD_WIDTH){i_offset[COORD_WIDTH-1]}}, i_offset});
    end

    always_ff @(posedge i_clk) begin
        r_ofs <= n_ofs;
    end

    always_comb begin
        fits = (&r_ofs[OFS_W-1:COORD_WIDTH-1]) || !(|r_ofs[OFS_W-1:COORD_WIDTH-1]);
        if (fits) begin
            n_value = r_ofs[COORD_WIDTH-1:0];
            n_sat   = 1'b0;
        end else begin
            n_value = r_ofs[OFS_W-1] ? COORD_MIN : COORD_MAX;
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule
`default_nettype wire

[design/quaternion_point_rotator_top.sv]
// Top level of the quaternion point rotator: register file, valid pipeline, three lanes.
// Depends on qpr_pkg, qpr_coef and qpr_lane.
`timescale 1ns / 1ps
`default_nettype none
// Rotates one Q16.16 point per request by the configured Q1.14 quaternion
// (q * v * conj(q), written out as its rotation matrix) and adds the configured
// offset; each coordinate is rounded half up once and saturated to Q16.16,
// and the saturated bit reports any clipping. The block takes a request in
// every cycle (busy stays low). o_strobe and the result on o_result come up
// together; the point passes r_pt1, r_pt2 and r_pt3 while the rotation
// matrix settles from the register file, then one register each holds the
// products of the 34x32 multipliers, the three-way sum, the offset add and
// the saturation, which is the output register. Results come in request
// order and cannot be held off; take them in the cycle that o_strobe marks.
// Write configuration only while no request is in flight. Register indexes:
// 0..3 quaternion w, x, y, z; 4..6 offset x, y, z; writes to other indexes
// are dropped.
module quaternion_point_rotator_top
    import qpr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_point                i_point,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int LATENCY = 7;

    logic signed [QUAT_WIDTH-1:0]  r_qw, r_qx, r_qy, r_qz;
    logic signed [COORD_WIDTH-1:0] r_off_x, r_off_y, r_off_z;
    logic [LATENCY-1:0]            r_vld;
    t_point                        r_pt1, r_pt2, r_pt3;
    t_coef_mat                     coef;
    logic                          sat_x, sat_y, sat_z;
    logic                          accept;

    // never stalls: a new request can enter in every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw    <= QUAT_ONE;
            r_qx    <= '0;
            r_qy    <= '0;
            r_qz    <= '0;
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUAT_W:   r_qw    <= i_cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_X:   r_qx    <= i_cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_Y:   r_qy    <= i_cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_Z:   r_qz    <= i_cfg_wdata[QUAT_WIDTH-1:0];
                REG_OFFSET_X: r_off_x <= i_cfg_wdata[COORD_WIDTH-1:0];
                REG_OFFSET_Y: r_off_y <= i_cfg_wdata[COORD_WIDTH-1:0];
                REG_OFFSET_Z: r_off_z <= i_cfg_wdata[COORD_WIDTH-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // advance the valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    // r_pt1..r_pt3 delay the point so a fresh configuration reaches the matrix first
    always_ff @(posedge i_clk) begin
        r_pt1 <= i_point;
        r_pt2 <= r_pt1;
        r_pt3 <= r_pt2;
    end

    qpr_coef u_coef (
        .i_clk  (i_clk),
        .i_qw   (r_qw),
        .i_qx   (r_qx),
        .i_qy   (r_qy),
        .i_qz   (r_qz),
        .o_coef (coef)
    );

    qpr_lane u_lane_x (
        .i_clk    (i_clk),
        .i_row    (coef.row_x),
        .i_point  (r_pt3),
        .i_offset (r_off_x),
        .o_value  (o_result.out_x),
        .o_sat    (sat_x)
    );

    qpr_lane u_lane_y (
        .i_clk    (i_clk),
        .i_row    (coef.row_y),
        .i_point  (r_pt3),
        .i_offset (r_off_y),
        .o_value  (o_result.out_y),
        .o_sat    (sat_y)
    );

    qpr_lane u_lane_z (
        .i_clk    (i_clk),
        .i_row    (coef.row_z),
        .i_point  (r_pt3),
        .i_offset (r_off_z),
        .o_value  (o_result.out_z),
        .o_sat    (sat_z)
    );

    assign o_result.saturated = sat_x || sat_y || sat_z;
    assign o_strobe           = r_vld[LATENCY-1];

    // every accepted request comes out as a strobed result
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("request did not produce a result on time");

    // no result without a matching request
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result without a request");

    // a clipped result sits on a range limit in at least one coordinate
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.saturated) |->
            (o_result.out_x == COORD_MAX || o_result.out_x == COORD_MIN ||
             o_result.out_y == COORD_MAX || o_result.out_y == COORD_MIN ||
             o_result.out_z == COORD_MAX || o_result.out_z == COORD_MIN))
        else $error("saturated flag without a clipped coordinate");

endmodule
`default_nettype wire

[sim/tb_quaternion_point_rotator_top.sv]
// Self-checking testbench of the quaternion point rotator top level.
// Depends on qpr_pkg and quaternion_point_rotator_top; predicts each result in place.
`timescale 1ns / 1ps
module tb_quaternion_point_rotator_top;
    import qpr_pkg::*;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;
    // Q16.16 one, and cos(45 deg) in Q1.14 for the stock rotations.
    localparam logic signed [COORD_WIDTH-1:0] FX_ONE = 32'sh0001_0000;
    localparam logic signed [31:0]            C45    = 32'sd11585;
    // Watchdog limit, with a wide margin over the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned RAND_PHASES = 9;
    localparam int unsigned PHASE_ITEMS = 150;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_point                 i_point;
    logic                   o_strobe;
    t_result                o_result;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    // Mirror of the register file, as the block should hold it.
    logic signed [QUAT_WIDTH-1:0]  rot_w, rot_x, rot_y, rot_z;
    logic signed [COORD_WIDTH-1:0] shift_x, shift_y, shift_z;

    // Rotated points still owed by the block, oldest first.
    t_result     pending_results[$];
    t_result     want;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    quaternion_point_rotator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One output coordinate: exact dot product of a matrix row with the point,
    // round half up out of the Q2.28 coefficient scale, add the offset, clip.
    // Returns {clipped, coordinate}.
    function automatic logic [COORD_WIDTH:0] rotate_lane(input longint c0, input longint c1,
                                                        input longint c2, input longint px,
                                                        input longint py, input longint pz,
                                                        input longint off);
        logic signed [127:0] k0, k1, k2, acc, hi_lim, lo_lim;
        k0     = c0;
        k1     = c1;
        k2     = c2;
        hi_lim = COORD_MAX;
        lo_lim = COORD_MIN;
        acc = k0 * px + k1 * py + k2 * pz;
        acc = (acc + (128'sd1 <<< (RSHIFT - 1))) >>> RSHIFT;
        acc = acc + off;
        if (acc > hi_lim)
            return {1'b1, COORD_MAX};
        if (acc < lo_lim)
            return {1'b1, COORD_MIN};
        return {1'b0, acc[COORD_WIDTH-1:0]};
    endfunction

    // Full rotation q * v * conj(q) in matrix form, plus offset; no normalization,
    // so a non-unit quaternion scales the point by |q|^2.
    function automatic t_result rotate_point(input t_point p);
        longint w, x, y, z, px, py, pz;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic [COORD_WIDTH:0] lx, ly, lz;
        t_result r;
        w  = rot_w;
        x  = rot_x;
        y  = rot_y;
        z  = rot_z;
        px = $signed(p.point_x);
        py = $signed(p.point_y);
        pz = $signed(p.point_z);
        ww = w * w;  xx = x * x;  yy = y * y;  zz = z * z;
        xy = x * y;  xz = x * z;  yz = y * z;
        wx = w * x;  wy = w * y;  wz = w * z;
        lx = rotate_lane(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy),
                         px, py, pz, shift_x);
        ly = rotate_lane(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx),
                         px, py, pz, shift_y);
        lz = rotate_lane(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz,
                         px, py, pz, shift_z);
        r.out_x     = lx[COORD_WIDTH-1:0];
        r.out_y     = ly[COORD_WIDTH-1:0];
        r.out_z     = lz[COORD_WIDTH-1:0];
        r.saturated = lx[COORD_WIDTH] | ly[COORD_WIDTH] | lz[COORD_WIDTH];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed point.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: x=%h y=%h z=%h sat=%b",
                         $time, o_result.out_x, o_result.out_y, o_result.out_z,
                         o_result.saturated);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.out_x !== want.out_x) begin
                    $display("%0t: out_x expected %h actual %h", $time, want.out_x,
                             o_result.out_x);
                    error_count++;
                end
                if (o_result.out_y !== want.out_y) begin
                    $display("%0t: out_y expected %h actual %h", $time, want.out_y,
                             o_result.out_y);
                    error_count++;
                end
                if (o_result.out_z !== want.out_z) begin
                    $display("%0t: out_z expected %h actual %h", $time, want.out_z,
                             o_result.out_z);
                    error_count++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                             o_result.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: drop out if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** quaternion_point_rotator_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered just after a rising edge and returns
    // just after one, so all drives land with the edge.
    // ------------------------------------------------------------------

    // Present one request, hold it until accepted, record its prediction,
    // then idle for the drawn gap. With no gap, start stays high.
    task automatic send_point(input t_point p, input int unsigned gap);
        start   <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results.push_back(rotate_point(p));
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    // With nothing owed, start is already low.
    task automatic wait_drain;
        if (pending_results.size() != 0)
            start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; track it in the mirror once it has been taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_QUAT_W:   rot_w   = data[QUAT_WIDTH-1:0];
            REG_QUAT_X:   rot_x   = data[QUAT_WIDTH-1:0];
            REG_QUAT_Y:   rot_y   = data[QUAT_WIDTH-1:0];
            REG_QUAT_Z:   rot_z   = data[QUAT_WIDTH-1:0];
            REG_OFFSET_X: shift_x = data[COORD_WIDTH-1:0];
            REG_OFFSET_Y: shift_y = data[COORD_WIDTH-1:0];
            REG_OFFSET_Z: shift_z = data[COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Drain, then load a whole rotation and offset; quaternion words are
    // passed full width so upper data bits get exercised too.
    task automatic set_rotation(input logic [31:0] qw, input logic [31:0] qx,
                                input logic [31:0] qy, input logic [31:0] qz,
                                input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz);
        wait_drain();
        write_reg(REG_QUAT_W, qw);
        write_reg(REG_QUAT_X, qx);
        write_reg(REG_QUAT_Y, qy);
        write_reg(REG_QUAT_Z, qz);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_point make_point(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // Coordinates: full range, small magnitudes that rarely clip, and corners.
    function automatic logic [31:0] rand_coord;
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                v = $urandom_range(0, 2097152);
                v = v - 32'sd1048576;
            end
            2: begin
                v = $urandom;
                v = v >>> $urandom_range(4, 24);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = COORD_MAX;
                    1: v = COORD_MIN;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = FX_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_offset;
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = 32'sd0;
            1: v = $urandom;
            2: begin
                v = $urandom_range(0, 2097152);
                v = v - 32'sd1048576;
            end
            default: v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        endcase
        return v;
    endfunction

    // Quaternion part from -1.0 to +1.0 in Q1.14, edges included.
    function automatic logic [31:0] rand_quat_part;
        logic signed [31:0] v;
        v = $urandom_range(0, 32768);
        return v - 32'sd16384;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values give the identity with no offset: points pass unchanged.
    task automatic test_reset_identity;
        send_point(make_point(32'd0, 32'd0, 32'd0), 0);
        send_point(make_point(COORD_MAX, COORD_MIN, 32'd1), 3);
        send_point(make_point(-32'sd1, FX_ONE, -FX_ONE), 0);
    endtask

    // Stock rotations, clipping both ways, non-unit and out-of-range quaternions.
    task automatic test_directed;
        // 90 degrees about z: x axis goes to y axis
        set_rotation(C45, 32'd0, 32'd0, C45, 32'd0, 32'd0, 32'd0);
        send_point(make_point(FX_ONE, 32'd0, 32'd0), 0);
        send_point(make_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0), 2);

        // 180 degrees about x with extreme offsets: x clips high, y clips low
        set_rotation(32'd0, 32'sd16384, 32'd0, 32'd0, COORD_MAX, COORD_MIN, 32'd0);
        send_point(make_point(FX_ONE, FX_ONE, FX_ONE), 1);
        send_point(make_point(32'd0, 32'd0, 32'd0), 0);

        // |q|^2 = 4: everything large clips, small points scale by four
        set_rotation(32'sd16384, 32'sd16384, 32'sd16384, 32'sd16384, 32'd0, 32'd0, 32'd0);
        send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX), 0);
        send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN), 0);
        send_point(make_point(32'sd3, -32'sd5, FX_ONE), 5);

        // Out-of-range parts, upper data bits set on a quaternion word,
        // and a write to the unmapped index that must change nothing.
        set_rotation(32'hFFFF_8000, 32'sd32767, -32'sd16384, 32'sd16384,
                     COORD_MIN, COORD_MIN, COORD_MIN);
        @(posedge i_clk);
        write_reg(IDX_UNMAPPED, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_point(make_point(COORD_MIN, COORD_MAX, 32'd0), 0);
        send_point(make_point(32'sd1, -32'sd1, FX_ONE), 0);
        send_point(make_point(32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_0000), 4);

        // -1 is also the identity; the offset takes the most negative x to -1
        set_rotation(-32'sd16384, 32'd0, 32'd0, 32'd0, COORD_MAX, 32'd0, COORD_MIN);
        send_point(make_point(COORD_MIN, 32'd0, -32'sd1), 0);
        send_point(make_point(COORD_MAX, 32'sd7, 32'sd1), 0);
    endtask

    // Phases of random points under random settings; some phases run
    // back to back, the rest with random gaps.
    task automatic test_random;
        t_point      p;
        int unsigned ph, n, gap, axis;
        logic [31:0] qw, qv, q1, q2, q3;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    qw = rand_quat_part();
                    q1 = rand_quat_part();
                    q2 = rand_quat_part();
                    q3 = rand_quat_part();
                end
                1: begin
                    // unit 90 degree turn about a random axis
                    qw   = $urandom_range(0, 1) ? C45 : -C45;
                    qv   = $urandom_range(0, 1) ? C45 : -C45;
                    axis = $urandom_range(1, 3);
                    q1   = (axis == 1) ? qv : 32'd0;
                    q2   = (axis == 2) ? qv : 32'd0;
                    q3   = (axis == 3) ? qv : 32'd0;
                end
                default: begin
                    // raw words: any 16-bit part, junk in the upper bits
                    qw = $urandom;
                    q1 = $urandom;
                    q2 = $urandom;
                    q3 = $urandom;
                end
            endcase
            set_rotation(qw, q1, q2, q3, rand_offset(), rand_offset(), rand_offset());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                p = make_point(rand_coord(), rand_coord(), rand_coord());
                if (ph % 4 == 1)
                    gap = 0;
                else
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
                // hold off mid-stream now and then until the pipe is empty
                if ((ph == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0)
                    wait_drain();
                send_point(p, gap);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_point     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_QUAT_W;
        i_cfg_wdata <= '0;
        rot_w   = QUAT_ONE;
        rot_x   = '0;
        rot_y   = '0;
        rot_z   = '0;
        shift_x = '0;
        shift_y = '0;
        shift_z = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_identity();
        test_directed();
        test_random();

        // Let the last results out, then give the pipe time for strays.
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("** quaternion_point_rotator_top: PASSED **");
        else
            $display("** quaternion_point_rotator_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
design/qpr_pkg.sv
design/qpr_coef.sv
design/qpr_lane.sv
design/quaternion_point_rotator_top.sv
sim/tb_quaternion_point_rotator_top.sv
